### design/scpd_pkg.sv
// Package for the script push-data parser: item types, role and phase codes,
// and the opcode classification helpers.
// No dependencies; every other design file imports it.
package scpd_pkg;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Byte roles reported with each result item.
    localparam logic [2:0] ROLE_PLAIN  = 3'd0;
    localparam logic [2:0] ROLE_PUSH   = 3'd1;
    localparam logic [2:0] ROLE_LENGTH = 3'd2;
    localparam logic [2:0] ROLE_DATA   = 3'd3;

    // Parser phases. The unused code is treated as expecting an opcode.
    localparam logic [1:0] PH_OPCODE = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;

    // Opcode classes found by the front.
    localparam logic [1:0] CLS_PLAIN    = 2'd0;
    localparam logic [1:0] CLS_DIRECT   = 2'd1;
    localparam logic [1:0] CLS_PUSHDATA = 2'd2;

    // Opcodes that carry an explicit length field of 1, 2 or 4 bytes.
    localparam logic [7:0] OP_PUSH_LEN1B = 8'h4C;
    localparam logic [7:0] OP_PUSH_LEN2B = 8'h4D;
    localparam logic [7:0] OP_PUSH_LEN4B = 8'h4E;

    typedef struct packed {
        logic [7:0] script_byte;
        logic       end_of_script;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  byte_role;
        logic [7:0]  current_opcode;
        logic [31:0] push_length;
        logic        instruction_done;
        logic        truncated_error;
        logic        script_done;
    } out_item_t;

    // Classification of a byte, meaningful when the byte is an opcode.
    typedef struct packed {
        logic [1:0] kind;
        logic       is_zero;
        logic [2:0] len_size;
    } byte_cls_t;

    // One queue entry: the raw item and its classification.
    typedef struct packed {
        in_item_t  item;
        byte_cls_t cls;
    } queue_entry_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic not_empty;
        logic full;
    } queue_status_t;

    // Number of length bytes that follow a PUSHDATA opcode.
    function automatic logic [2:0] len_field_size(input logic [7:0] op);
        logic [2:0] size;
        begin
            case (op)
                OP_PUSH_LEN1B: size = 3'd1;
                OP_PUSH_LEN2B: size = 3'd2;
                OP_PUSH_LEN4B: size = 3'd4;
                default:       size = 3'd0;
            endcase
            return size;
        end
    endfunction

endpackage

### design/scpd_front.sv
// Front of the script push-data parser: accepts input items and classifies
// each byte as an opcode before it enters the queue. Depends on scpd_pkg.
module scpd_front
    import scpd_pkg::*;
(
    input  logic          in_valid,
    output logic          in_ready,
    input  in_item_t      in_item,
    input  queue_status_t q_status,
    output logic          q_push,
    output queue_entry_t  q_wdata
);

    byte_cls_t cls;

    // Accept whenever the queue has room.
    assign in_ready = !q_status.full;
    assign q_push   = in_valid && in_ready;

    // Classify the byte as a direct push, a PUSHDATA opcode or a plain opcode.
    always_comb
    begin
        cls.is_zero  = (in_item.script_byte == 8'h00);
        cls.len_size = len_field_size(in_item.script_byte);
        if (in_item.script_byte < OP_PUSH_LEN1B)
        begin
            cls.kind = CLS_DIRECT;
        end
        else if (in_item.script_byte <= OP_PUSH_LEN4B)
        begin
            cls.kind = CLS_PUSHDATA;
        end
        else
        begin
            cls.kind = CLS_PLAIN;
        end
    end

    assign q_wdata.item = in_item;
    assign q_wdata.cls  = cls;

endmodule

### design/scpd_queue.sv
// Short queue between the front and the back of the push-data parser.
// Depends on scpd_pkg for the entry and status types.
module scpd_queue
    import scpd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  queue_entry_t  wdata,
    input  logic          pop,
    output queue_entry_t  rdata,
    output queue_status_t status
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    queue_entry_t     mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign status.not_empty = (count_reg != '0);
    assign status.full      = (count_reg == FULL_CNT);
    assign rdata            = mem[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count exceeds depth");

    // No entry is written into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.full |-> !push)
        else $error("push into full queue");

    // No entry is taken from an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !status.not_empty |-> !pop)
        else $error("pop from empty queue");

endmodule

### design/scpd_back.sv
// Back of the push-data parser: holds the parse state, turns each queued item
// into one result item and keeps it in the output register.
// Depends on scpd_pkg.
module scpd_back
    import scpd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t q_status,
    input  queue_entry_t  q_rdata,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output out_item_t     out_item
);

    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic [7:0]  held_opcode_reg;
    logic [7:0]  held_opcode_next;
    logic [2:0]  len_left_reg;
    logic [2:0]  len_left_next;
    logic [31:0] len_shift_reg;
    logic [31:0] len_shift_next;
    logic [31:0] data_left_reg;
    logic [31:0] data_left_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_item_t   out_item_reg;
    out_item_t   result;

    logic [7:0]  b;
    logic        eos;
    logic [2:0]  len_idx;
    logic [31:0] len_merged;

    assign b   = q_rdata.item.script_byte;
    assign eos = q_rdata.item.end_of_script;

    // Take the next item when the output register is free or being emptied.
    assign q_pop = q_status.not_empty && (!out_valid_reg || out_ready);

    // Position of the incoming length byte, least significant first.
    assign len_idx = len_field_size(held_opcode_reg) - len_left_reg;

    // Merge the length byte into the assembled length.
    always_comb
    begin
        case (len_idx[1:0])
            2'd0:    len_merged = len_shift_reg | {24'h0, b};
            2'd1:    len_merged = len_shift_reg | {16'h0, b, 8'h0};
            2'd2:    len_merged = len_shift_reg | {8'h0, b, 16'h0};
            default: len_merged = len_shift_reg | {b, 24'h0};
        endcase
    end

    // Parse step for the item at the head of the queue.
    always_comb
    begin
        phase_next       = phase_reg;
        held_opcode_next = held_opcode_reg;
        len_left_next    = len_left_reg;
        len_shift_next   = len_shift_reg;
        data_left_next   = data_left_reg;
        result           = '0;
        result.script_done = eos;

        case (phase_reg)
            PH_LENGTH:
            begin
                result.byte_role = ROLE_LENGTH;
                len_shift_next   = len_merged;
                len_left_next    = len_left_reg - 3'd1;
                if (len_left_next == 3'd0)
                begin
                    if (len_merged == 32'h0)
                    begin
                        result.instruction_done = 1'b1;
                        phase_next = PH_OPCODE;
                    end
                    else
                    begin
                        data_left_next = len_merged;
                        phase_next     = PH_DATA;
                    end
                end
                result.push_length = len_merged;
            end
            PH_DATA:
            begin
                result.byte_role   = ROLE_DATA;
                result.push_length = len_shift_reg;
                data_left_next     = data_left_reg - 32'd1;
                if (data_left_reg == 32'd1)
                begin
                    result.instruction_done = 1'b1;
                    phase_next = PH_OPCODE;
                end
            end
            default:
            begin
                held_opcode_next = b;
                len_shift_next   = 32'h0;
                data_left_next   = 32'h0;
                len_left_next    = 3'd0;
                phase_next       = PH_OPCODE;
                case (q_rdata.cls.kind)
                    CLS_DIRECT:
                    begin
                        result.byte_role   = ROLE_PUSH;
                        len_shift_next     = {24'h0, b};
                        result.push_length = {24'h0, b};
                        if (q_rdata.cls.is_zero)
                        begin
                            result.instruction_done = 1'b1;
                        end
                        else
                        begin
                            data_left_next = {24'h0, b};
                            phase_next     = PH_DATA;
                        end
                    end
                    CLS_PUSHDATA:
                    begin
                        result.byte_role = ROLE_PUSH;
                        len_left_next    = q_rdata.cls.len_size;
                        phase_next       = PH_LENGTH;
                    end
                    default:
                    begin
                        result.byte_role        = ROLE_PLAIN;
                        result.instruction_done = 1'b1;
                    end
                endcase
            end
        endcase

        // A script that ends inside a length or data field is truncated.
        if (eos && (phase_next == PH_LENGTH || phase_next == PH_DATA))
        begin
            result.truncated_error  = 1'b1;
            result.instruction_done = 1'b0;
        end

        result.current_opcode = held_opcode_next;

        // The end of a script returns the parser to its reset state.
        if (eos)
        begin
            phase_next       = PH_OPCODE;
            held_opcode_next = 8'h0;
            len_left_next    = 3'd0;
            len_shift_next   = 32'h0;
            data_left_next   = 32'h0;
        end
    end

    // Output register occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Parse state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_OPCODE;
            held_opcode_reg <= 8'h0;
            len_left_reg    <= 3'd0;
            len_shift_reg   <= 32'h0;
            data_left_reg   <= 32'h0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                phase_reg       <= phase_next;
                held_opcode_reg <= held_opcode_next;
                len_left_reg    <= len_left_next;
                len_shift_reg   <= len_shift_next;
                data_left_reg   <= data_left_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // A truncation is only reported on the last item of a script.
    a_trunc_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.truncated_error |-> out_item_reg.script_done)
        else $error("truncation reported before end of script");

    // A truncated instruction is never reported as completed.
    a_trunc_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_item_reg.truncated_error && out_item_reg.instruction_done))
        else $error("truncated item marked done");

    // Parsing restarts at an opcode after the last item of a script.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && eos |=> (phase_reg == PH_OPCODE && len_shift_reg == 32'h0))
        else $error("parse state not cleared at end of script");

    // While in the length phase there are length bytes still to come.
    a_len_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LENGTH |-> len_left_reg != 3'd0)
        else $error("length phase with no length bytes left");

endmodule

### design/script_push_data_parser_core.sv
// Script push-data parser: classifies each script byte as an opcode, length
// byte or data byte, one result item per input item.
// An accepted item passes through the queue and then the output register.
// Throughput: 1 item per cycle while out_ready is held high; the back's combinational parse step sets it.
// Reset (rst_n low, asynchronous): queue emptied, output invalid, parser
// returned to expecting an opcode with all held values cleared.
module script_push_data_parser_core
    import scpd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    queue_status_t q_status;
    queue_entry_t  q_wdata;
    queue_entry_t  q_rdata;
    logic          q_push;
    logic          q_pop;

    // Front: accept and classify.
    scpd_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_status (q_status),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    // Queue between front and back.
    scpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .status (q_status)
    );

    // Back: parse and hold the result.
    scpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
